// File: rtl/rsc_pkg.sv
// rpn stack calculator shared types and constants
`default_nettype none
package rsc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int OP_W      = 4;
    localparam int PEEK_W    = 6;
    localparam int ST_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_POP   = 4'd5,
        OP_PEEK  = 4'd6,
        OP_DUP   = 4'd7,
        OP_SWAP  = 4'd8,
        OP_CLEAR = 4'd9
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 3'd0,
        ST_FULL = 3'd1,
        ST_EMPTY = 3'd2,
        ST_ZDIV = 3'd3,
        ST_PEEK = 3'd4,
        ST_DUPE = 3'd5,
        ST_SWAP = 3'd6,
        ST_UNK  = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        AS_TOP,
        AS_TOP2,
        AS_PEEK,
        AS_CNT
    } t_addr_sel;

    typedef enum logic [1:0] {
        WD_OPERAND,
        WD_RESULT,
        WD_B,
        WD_RDATA
    } t_wd_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POPB,
        S_LDB,
        S_AFTB,
        S_POPA,
        S_LDA,
        S_EXEC,
        S_WAIT,
        S_PUSH,
        S_PEEK_LD,
        S_DUP_WR,
        S_SW_B,
        S_SW_A,
        S_SW_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic      latch;
        logic      rd;
        t_addr_sel rd_sel;
        logic      wr;
        t_addr_sel wr_sel;
        t_wd_sel   wd_sel;
        logic      inc_cnt;
        logic      dec_cnt;
        logic      clr_cnt;
        logic      ld_b;
        logic      clr_b;
        logic      ld_a;
        logic      clr_a;
        logic      show;
        logic      set_st;
        t_status   st;
        logic      arith_start;
        logic      res_addsub;
        logic      res_sat;
        t_op       op;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic cnt_lt2;
        logic peek_ok;
        logic b_zero;
        logic arith_done;
    } t_dp_stat;

endpackage
`default_nettype wire

// File: rtl/rsc_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module rsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

// File: rtl/rsc_ctrl.sv
// rpn stack calculator command sequencer
`default_nettype none
module rsc_ctrl
    import rsc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire t_dp_stat            i_stat,
    output t_cmd                     o_cmd,
    output logic                     busy,
    output logic                     o_done
);
    t_state r_state, n_state;
    t_op    r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_PUSH;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        o_cmd    = '0;
        o_cmd.op = r_op;
        busy     = 1'b1;
        o_done   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_op        = t_op'(i_operation);
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (r_op)
                    OP_PUSH: begin
                        if (i_stat.cnt_full) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_FULL;
                        end else begin
                            o_cmd.wr      = 1'b1;
                            o_cmd.wr_sel  = AS_CNT;
                            o_cmd.wd_sel  = WD_OPERAND;
                            o_cmd.inc_cnt = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POP: begin
                        n_state = S_POPB;
                    end
                    OP_PEEK: begin
                        if (i_stat.peek_ok) begin
                            o_cmd.rd     = 1'b1;
                            o_cmd.rd_sel = AS_PEEK;
                            n_state      = S_PEEK_LD;
                        end else begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_PEEK;
                        end
                    end
                    OP_DUP: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_DUPE;
                        end else if (i_stat.cnt_full) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_FULL;
                        end else begin
                            o_cmd.rd     = 1'b1;
                            o_cmd.rd_sel = AS_TOP;
                            n_state      = S_DUP_WR;
                        end
                    end
                    OP_SWAP: begin
                        if (i_stat.cnt_lt2) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_SWAP;
                        end else begin
                            o_cmd.rd     = 1'b1;
                            o_cmd.rd_sel = AS_TOP;
                            n_state      = S_SW_B;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clr_cnt = 1'b1;
                    end
                    default: begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = ST_UNK;
                    end
                endcase
            end
            S_POPB: begin
                if (i_stat.cnt_zero) begin
                    o_cmd.clr_b  = 1'b1;
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_EMPTY;
                    n_state      = S_AFTB;
                end else begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.rd_sel  = AS_TOP;
                    o_cmd.dec_cnt = 1'b1;
                    n_state       = S_LDB;
                end
            end
            S_LDB: begin
                o_cmd.ld_b = 1'b1;
                n_state    = S_AFTB;
            end
            S_AFTB: begin
                if (r_op == OP_POP) begin
                    o_cmd.show = 1'b1;
                    n_state    = S_DONE;
                end else if (r_op == OP_DIV && i_stat.b_zero) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_ZDIV;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_POPA;
                end
            end
            S_POPA: begin
                if (i_stat.cnt_zero) begin
                    o_cmd.clr_a  = 1'b1;
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_EMPTY;
                    n_state      = S_EXEC;
                end else begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.rd_sel  = AS_TOP;
                    o_cmd.dec_cnt = 1'b1;
                    n_state       = S_LDA;
                end
            end
            S_LDA: begin
                o_cmd.ld_a = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                if (r_op == OP_MUL || r_op == OP_DIV) begin
                    o_cmd.arith_start = 1'b1;
                    n_state           = S_WAIT;
                end else begin
                    o_cmd.res_addsub = 1'b1;
                    n_state          = S_PUSH;
                end
            end
            S_WAIT: begin
                if (i_stat.arith_done) begin
                    o_cmd.res_sat = 1'b1;
                    n_state       = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_sel  = AS_CNT;
                o_cmd.wd_sel  = WD_RESULT;
                o_cmd.inc_cnt = 1'b1;
                n_state       = S_DONE;
            end
            S_PEEK_LD: begin
                o_cmd.ld_b = 1'b1;
                o_cmd.show = 1'b1;
                n_state    = S_DONE;
            end
            S_DUP_WR: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_sel  = AS_CNT;
                o_cmd.wd_sel  = WD_RDATA;
                o_cmd.inc_cnt = 1'b1;
                n_state       = S_DONE;
            end
            S_SW_B: begin
                o_cmd.ld_b   = 1'b1;
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = AS_TOP2;
                n_state      = S_SW_A;
            end
            S_SW_A: begin
                o_cmd.wr     = 1'b1;
                o_cmd.wr_sel = AS_TOP;
                o_cmd.wd_sel = WD_RDATA;
                n_state      = S_SW_WR;
            end
            S_SW_WR: begin
                o_cmd.wr     = 1'b1;
                o_cmd.wr_sel = AS_TOP2;
                o_cmd.wd_sel = WD_B;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/rsc_datapath.sv
// rpn stack calculator datapath: stack memory, count, serial mul and div
`default_nettype none
module rsc_datapath
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire t_cmd                             i_cmd,
    input  wire logic signed [VALUE_WIDTH-1:0]    i_operand_value,
    input  wire logic [PEEK_W-1:0]                i_peek_offset,
    output t_dp_stat                              o_stat,
    output logic signed [VALUE_WIDTH-1:0]         o_shown_value,
    output logic [ST_W-1:0]                       o_status,
    output logic [$clog2(STACK_DEPTH+1)-1:0]      o_stack_depth
);
    localparam int W   = VALUE_WIDTH;
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int XW  = CW + PEEK_W;
    localparam int NW  = W + FRAC_BITS;
    localparam int ITW = $clog2(NW + 1);

    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    logic [CW-1:0]     r_count;
    logic [W-1:0]      r_operand;
    logic [PEEK_W-1:0] r_offset;
    t_status           r_status;
    logic              r_show;
    logic [W-1:0]      r_a, r_b, r_res;

    logic [W-1:0]      r_x, r_y;
    logic              r_neg, r_is_div;
    logic [W:0]        r_acc;
    logic [W-1:0]      r_lo;
    logic [W-1:0]      r_rem;
    logic [NW-1:0]     r_num;
    logic [ITW-1:0]    r_it;

    logic [W-1:0]      rd_data, wr_data;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [CW-1:0]     cnt_m1, cnt_m2;
    logic [XW-1:0]     peek_idx;

    assign cnt_m1   = r_count - CW'(1);
    assign cnt_m2   = r_count - CW'(2);
    assign peek_idx = XW'(r_count) - XW'(r_offset) - XW'(1);

    assign o_stat.cnt_zero   = (r_count == '0);
    assign o_stat.cnt_full   = (r_count == CW'(STACK_DEPTH));
    assign o_stat.cnt_lt2    = (r_count < CW'(2));
    assign o_stat.peek_ok    = (XW'(r_offset) < XW'(r_count));
    assign o_stat.b_zero     = (r_b == '0);
    assign o_stat.arith_done = (r_it == '0);

    always_comb begin
        unique case (i_cmd.rd_sel)
            AS_TOP:  rd_addr = cnt_m1[AW-1:0];
            AS_TOP2: rd_addr = cnt_m2[AW-1:0];
            AS_PEEK: rd_addr = peek_idx[AW-1:0];
            AS_CNT:  rd_addr = r_count[AW-1:0];
        endcase
        unique case (i_cmd.wr_sel)
            AS_TOP:  wr_addr = cnt_m1[AW-1:0];
            AS_TOP2: wr_addr = cnt_m2[AW-1:0];
            AS_PEEK: wr_addr = peek_idx[AW-1:0];
            AS_CNT:  wr_addr = r_count[AW-1:0];
        endcase
        unique case (i_cmd.wd_sel)
            WD_OPERAND: wr_data = r_operand;
            WD_RESULT:  wr_data = r_res;
            WD_B:       wr_data = r_b;
            WD_RDATA:   wr_data = rd_data;
        endcase
    end

    rsc_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // add and sub with saturation
    logic [W:0]   addsub;
    logic [W-1:0] addsub_sat;
    always_comb begin
        if (i_cmd.op == OP_SUB) begin
            addsub = {r_a[W-1], r_a} - {r_b[W-1], r_b};
        end else begin
            addsub = {r_a[W-1], r_a} + {r_b[W-1], r_b};
        end
        if (addsub[W] != addsub[W-1]) begin
            addsub_sat = addsub[W] ? VMIN : VMAX;
        end else begin
            addsub_sat = addsub[W-1:0];
        end
    end

    // operand magnitudes
    logic [W-1:0] mag_a, mag_b;
    assign mag_a = r_a[W-1] ? (W'(0) - r_a) : r_a;
    assign mag_b = r_b[W-1] ? (W'(0) - r_b) : r_b;

    // serial step values
    logic [W:0]     mul_sum;
    logic [W:0]     div_shift;
    logic           div_ge;
    logic [W:0]     div_diff;
    assign mul_sum   = r_acc + (r_lo[0] ? {1'b0, r_x} : '0);
    assign div_shift = {r_rem, r_num[NW-1]};
    assign div_ge    = (div_shift >= {1'b0, r_y});
    assign div_diff  = div_shift - {1'b0, r_y};

    // final saturation of the magnitude
    logic [2*W-1:0] product, qmag, lim;
    logic [W-1:0]   sat_val;
    assign product = {r_acc[W-1:0], r_lo};
    assign qmag    = r_is_div ? (2*W)'(r_num) : (product >> FRAC_BITS);
    assign lim     = (2*W)'(VMAX) + (2*W)'(r_neg);
    always_comb begin
        if (qmag > lim) begin
            sat_val = r_neg ? VMIN : VMAX;
        end else if (r_neg) begin
            sat_val = W'(0) - qmag[W-1:0];
        end else begin
            sat_val = qmag[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_it    <= '0;
            r_show  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            if (i_cmd.latch) begin
                r_operand <= i_operand_value;
                r_offset  <= i_peek_offset;
                r_status  <= ST_OK;
                r_show    <= 1'b0;
            end
            if (i_cmd.set_st) begin
                r_status <= i_cmd.st;
            end
            if (i_cmd.show) begin
                r_show <= 1'b1;
            end
            if (i_cmd.clr_cnt) begin
                r_count <= '0;
            end else if (i_cmd.inc_cnt) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_cnt) begin
                r_count <= cnt_m1;
            end
            if (i_cmd.arith_start) begin
                r_it <= (i_cmd.op == OP_DIV) ? ITW'(NW) : ITW'(W);
            end else if (r_it != '0) begin
                r_it <= r_it - ITW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_b) begin
            r_b <= rd_data;
        end else if (i_cmd.clr_b) begin
            r_b <= '0;
        end
        if (i_cmd.ld_a) begin
            r_a <= rd_data;
        end else if (i_cmd.clr_a) begin
            r_a <= '0;
        end
        if (i_cmd.res_addsub) begin
            r_res <= addsub_sat;
        end else if (i_cmd.res_sat) begin
            r_res <= sat_val;
        end
        if (i_cmd.arith_start) begin
            r_x      <= mag_a;
            r_y      <= mag_b;
            r_neg    <= r_a[W-1] ^ r_b[W-1];
            r_is_div <= (i_cmd.op == OP_DIV);
            r_acc    <= '0;
            r_lo     <= mag_b;
            r_rem    <= '0;
            r_num    <= {mag_a, {FRAC_BITS{1'b0}}};
        end else if (r_it != '0) begin
            if (r_is_div) begin
                r_rem <= div_ge ? div_diff[W-1:0] : div_shift[W-1:0];
                r_num <= {r_num[NW-2:0], div_ge};
            end else begin
                r_acc <= {1'b0, mul_sum[W:1]};
                r_lo  <= {mul_sum[0], r_lo[W-1:1]};
            end
        end
    end

    assign o_shown_value = (r_show && r_status == ST_OK) ? r_b : '0;
    assign o_status      = r_status;
    assign o_stack_depth = r_count;
endmodule
`default_nettype wire

// File: rtl/rpn_stack_calculator_top.sv
// rpn stack calculator top level
// push, clear and unknown commands finish in decode, then give the done beat
// pop, peek, add, sub, dup and swap step through stack read and write states
// mul and div wait on a bit-serial multiplier and a bit-serial divider
// one command at a time: busy stays high from acceptance through the done beat
// synchronous active-low reset empties the stack; memory contents are not cleared
`default_nettype none
module rpn_stack_calculator_top
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [OP_W-1:0]                     i_operation,
    input  wire logic signed [VALUE_WIDTH-1:0]       i_operand_value,
    input  wire logic [PEEK_W-1:0]                   i_peek_offset,
    output logic                                     o_done,
    output logic signed [VALUE_WIDTH-1:0]            o_shown_value,
    output logic [ST_W-1:0]                          o_status,
    output logic [$clog2(STACK_DEPTH+1)-1:0]         o_stack_depth
);
    t_cmd     cmd;
    t_dp_stat stat;

    rsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .busy        (busy),
        .o_done      (o_done)
    );

    rsc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operand_value (i_operand_value),
        .i_peek_offset   (i_peek_offset),
        .o_stat          (stat),
        .o_shown_value   (o_shown_value),
        .o_status        (o_status),
        .o_stack_depth   (o_stack_depth)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done beat longer than one cycle");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_shown_value == '0))
        else $error("shown value nonzero on error");

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stack_depth <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_arith_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.arith_start |-> stat.arith_done)
        else $error("arithmetic unit restarted while running");
endmodule
`default_nettype wire
